>>> src/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, microcode word layout and program ROM for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Operand width of base, exponent, modulus and result
  localparam int WIDTH = 16;
  // Stream data width: operand padded up to whole bytes
  localparam int DATA_W = ((WIDTH + 7) / 8) * 8;
  // Iteration counter width for per-bit loops over WIDTH
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  // Program counter
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_LOAD   = 3'd0;
  localparam pc_t STEP_REDUCE = 3'd1;
  localparam pc_t STEP_TEST   = 3'd2;
  localparam pc_t STEP_MULT   = 3'd3;
  localparam pc_t STEP_SQUARE = 3'd4;
  localparam pc_t STEP_NEXT   = 3'd5;
  localparam pc_t STEP_EMIT   = 3'd6;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,  // wait for a base beat, initialize the datapath
    OP_MUL  = 3'd1,  // run one modular multiplication
    OP_TEST = 3'd2,  // jump to target when the current exponent bit is clear
    OP_NEXT = 3'd3,  // shift exponent, loop to target until all bits are done
    OP_EMIT = 3'd4   // hand the result to the output register, jump to target
  } op_t;

  typedef enum logic {
    SRC_A_ACC = 1'b0,
    SRC_A_RUN = 1'b1
  } src_a_t;

  typedef enum logic {
    SRC_B_ONE = 1'b0,
    SRC_B_RUN = 1'b1
  } src_b_t;

  typedef enum logic {
    DST_ACC = 1'b0,
    DST_RUN = 1'b1
  } dst_t;

  typedef struct packed {
    op_t    op;
    src_a_t src_a;
    src_b_t src_b;
    dst_t   dst;
    pc_t    target;
  } ucode_t;

  // Program ROM
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    w = '{op: OP_LOAD, src_a: SRC_A_RUN, src_b: SRC_B_ONE, dst: DST_RUN,
          target: STEP_LOAD};
    unique case (pc)
      STEP_LOAD:   w.op = OP_LOAD;
      STEP_REDUCE: begin
        // run = base mod m (multiply by one)
        w.op = OP_MUL; w.src_a = SRC_A_RUN; w.src_b = SRC_B_ONE; w.dst = DST_RUN;
      end
      STEP_TEST: begin
        w.op = OP_TEST; w.target = STEP_SQUARE;
      end
      STEP_MULT: begin
        w.op = OP_MUL; w.src_a = SRC_A_ACC; w.src_b = SRC_B_RUN; w.dst = DST_ACC;
      end
      STEP_SQUARE: begin
        w.op = OP_MUL; w.src_a = SRC_A_RUN; w.src_b = SRC_B_RUN; w.dst = DST_RUN;
      end
      STEP_NEXT: begin
        w.op = OP_NEXT; w.target = STEP_TEST;
      end
      STEP_EMIT: begin
        w.op = OP_EMIT; w.target = STEP_LOAD;
      end
      default: w.op = OP_LOAD;
    endcase
    return w;
  endfunction

endpackage

>>> src/modexp_modmul.sv
// ----------------------------------------------------------------------------
// modexp_modmul
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module modexp_modmul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [modexp_pkg::WIDTH-1:0] a,
  input  logic [modexp_pkg::WIDTH-1:0] b,      // must not exceed m
  input  logic [modexp_pkg::WIDTH:0]   m,      // effective modulus, 1 .. 2^WIDTH
  output logic                         busy,
  output logic                         done,
  output logic [modexp_pkg::WIDTH-1:0] product
);

  localparam int W   = modexp_pkg::WIDTH;
  localparam int T_W = W + 2;

  logic [W-1:0]                 rem;
  logic [W-1:0]                 a_sh;
  logic [W-1:0]                 b_reg;
  logic [modexp_pkg::CNT_W-1:0] cnt;

  logic [T_W-1:0] t;
  logic [T_W-1:0] m1;
  logic [T_W-1:0] m2;
  logic [W-1:0]   rem_next;

  // t = 2*rem + bit*b stays below 3m, so at most 2m comes off
  always_comb begin
    t  = {1'b0, rem, 1'b0} + (a_sh[W-1] ? T_W'(b_reg) : '0);
    m1 = T_W'(m);
    m2 = {m, 1'b0};
    priority if (t >= m2) begin
      rem_next = W'(t - m2);
    end else if (t >= m1) begin
      rem_next = W'(t - m1);
    end else begin
      rem_next = W'(t);
    end
  end

  assign done    = busy && (cnt == modexp_pkg::CNT_W'(W - 1));
  assign product = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      rem   <= '0;
      a_sh  <= a;
      b_reg <= b;
      cnt   <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      a_sh <= {a_sh[W-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each base beat to the configured exponent modulo the configured
// modulus with right-to-left square-and-multiply under microcode control.
// ----------------------------------------------------------------------------
// Usage:
//   Write the exponent (index 0) and modulus (index 1) through cfg_* while
//   the block is idle. Send bases on s_axis; each base yields exactly one
//   result beat on m_axis. An exponent of zero returns 1, unreduced.
//   A modulus of zero reduces modulo 2^WIDTH.
// Operation (W = WIDTH, one base in work at a time): a base is reduced once,
//   then each of the W steps of the exponent loop squares the running power
//   and, for a set exponent bit, first multiplies it into the accumulator. The
//   time per base is set by the bit-serial modular multiplier (one bit per
//   cycle) and this W-step exponent loop of the microprogram.
// Reset: returns to the load step, empties the output register, sets the
//   exponent to 0 and the modulus to 1.
// Stall: the result sits in the output register until taken; the next base
//   is accepted meanwhile and is computed, but the emit step holds until the
//   output register is free.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                                    clk,
  input  logic                                    rst,
  // Configuration
  input  logic                                    cfg_wr_en,
  input  logic [modexp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [modexp_pkg::WIDTH-1:0]            cfg_data,
  // Base input
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [modexp_pkg::DATA_W-1:0]           s_axis_tdata,   // [W-1:0] base
  // Result output
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [modexp_pkg::DATA_W-1:0]           m_axis_tdata    // [W-1:0] power_mod
);

  localparam int W = modexp_pkg::WIDTH;

  // Configuration registers
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;
  logic [W:0]   m_eff;

  // Sequencer
  modexp_pkg::pc_t    pc;
  modexp_pkg::ucode_t uw;

  // Datapath
  logic [W-1:0]                 acc;
  logic [W-1:0]                 run;
  logic [W-1:0]                 ebits;
  logic [modexp_pkg::CNT_W-1:0] bitcnt;
  logic [W-1:0]                 out_data;
  logic                         out_valid;
  logic                         emit_go;

  // Multiplier
  logic         mm_start;
  logic         mm_busy;
  logic         mm_done;
  logic [W-1:0] mm_a;
  logic [W-1:0] mm_b;
  logic [W-1:0] mm_product;

  // Zero modulus means wrap at the register width
  assign m_eff = (modulus == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus};

  assign uw = modexp_pkg::ucode_rom(pc);

  assign s_axis_tready = (uw.op == modexp_pkg::OP_LOAD);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = modexp_pkg::DATA_W'(out_data);

  // Emit proceeds when the output register is empty or being emptied
  assign emit_go = (uw.op == modexp_pkg::OP_EMIT) && (!out_valid || m_axis_tready);

  // Kick the multiplier on entry to a multiply step
  assign mm_start = (uw.op == modexp_pkg::OP_MUL) && !mm_busy;
  assign mm_a     = (uw.src_a == modexp_pkg::SRC_A_ACC) ? acc : run;
  assign mm_b     = (uw.src_b == modexp_pkg::SRC_B_RUN) ? run : W'(1);

  modexp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .m       (m_eff),
    .busy    (mm_busy),
    .done    (mm_done),
    .product (mm_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= modexp_pkg::STEP_LOAD;
      out_valid <= 1'b0;
      exponent  <= '0;
      modulus   <= W'(1);
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          modexp_pkg::REG_EXPONENT: exponent <= cfg_data;
          modexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
          default: ;
        endcase
      end

      // Raise the result on emit, drop it once the beat is taken
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (uw.op)
        modexp_pkg::OP_LOAD: begin
          if (s_axis_tvalid) begin
            run    <= s_axis_tdata[W-1:0];
            acc    <= W'(1);
            ebits  <= exponent;
            bitcnt <= '0;
            pc     <= pc + 1'b1;
          end
        end
        modexp_pkg::OP_MUL: begin
          if (mm_done) begin
            if (uw.dst == modexp_pkg::DST_ACC) begin
              acc <= mm_product;
            end else begin
              run <= mm_product;
            end
            pc <= pc + 1'b1;
          end
        end
        modexp_pkg::OP_TEST: begin
          pc <= ebits[0] ? pc + 1'b1 : uw.target;
        end
        modexp_pkg::OP_NEXT: begin
          ebits  <= ebits >> 1;
          bitcnt <= bitcnt + 1'b1;
          pc     <= (bitcnt == modexp_pkg::CNT_W'(W - 1)) ? pc + 1'b1 : uw.target;
        end
        modexp_pkg::OP_EMIT: begin
          // Hold until the output register is free
          if (emit_go) begin
            out_data <= acc;
            pc       <= uw.target;
          end
        end
        default: pc <= modexp_pkg::STEP_LOAD;
      endcase
    end
  end

  // Multiplier completes only under a multiply step
  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (uw.op == modexp_pkg::OP_MUL))
    else $error("multiplier finished outside a multiply step");

  // An accepted base goes straight to the reduction
  a_accept_reduce: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (pc == modexp_pkg::STEP_REDUCE))
    else $error("accepted base did not enter reduction");

  // A result appears only from the emit step
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(uw.op == modexp_pkg::OP_EMIT))
    else $error("result raised outside the emit step");

  // Running power stays reduced inside the exponent loop
  a_run_reduced: assert property (@(posedge clk) disable iff (rst)
    (uw.op == modexp_pkg::OP_NEXT) |-> ({1'b0, run} < m_eff))
    else $error("running power not reduced");

endmodule

>>> tb/power_mod_monitor.sv
// ----------------------------------------------------------------------------
// power_mod_monitor
// Watches the configuration port and both streams of the modular
// exponentiation block, computes base^exponent mod modulus for every
// accepted base beat and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module power_mod_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [modexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [modexp_pkg::WIDTH-1:0]        cfg_data,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [modexp_pkg::DATA_W-1:0]       s_axis_tdata,   // [W-1:0] base
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [modexp_pkg::DATA_W-1:0]       m_axis_tdata,   // [W-1:0] power_mod
  output int                                  fail_count,
  output int                                  in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH  = modexp_pkg::WIDTH;
  localparam int DATA_W = modexp_pkg::DATA_W;

  typedef logic [2*WIDTH-1:0] wide_t;

  logic [WIDTH-1:0] exponent_q;
  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] expected_power_q[$];

  // Modulus zero wraps at the register width instead of dividing.
  function automatic wide_t fold(wide_t x, logic [WIDTH-1:0] m);
    if (m == '0) return x & wide_t'({WIDTH{1'b1}});
    return x % wide_t'(m);
  endfunction

  // Right-to-left square-and-multiply; the base enters unreduced.
  function automatic logic [WIDTH-1:0] power_mod_of(logic [WIDTH-1:0] base,
                                                    logic [WIDTH-1:0] expo,
                                                    logic [WIDTH-1:0] m);
    wide_t acc;
    wide_t run;
    acc = wide_t'(1);
    run = wide_t'(base);
    for (int i = 0; i < WIDTH; i++) begin
      if (expo[i]) acc = fold(acc * run, m);
      run = fold(run * run, m);
    end
    return acc[WIDTH-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [WIDTH-1:0] want;
    if (rst) begin
      exponent_q <= '0;
      modulus_q  <= WIDTH'(1);
      expected_power_q.delete();
      fail_count <= 0;
      in_flight  <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          modexp_pkg::REG_EXPONENT: exponent_q <= cfg_data;
          modexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_power_q.push_back(power_mod_of(s_axis_tdata[WIDTH-1:0],
                                                exponent_q, modulus_q));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_power_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat %h with no base pending", $realtime,
                     m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_power_q.pop_front();
          if (m_axis_tdata !== DATA_W'(want)) begin
            if (fail_count < 10)
              $display("%0t: power_mod mismatch, expected %h got %h", $realtime,
                       DATA_W'(want), m_axis_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      in_flight <= expected_power_q.size();
    end
  end

endmodule

>>> tb/modular_exponentiation_test.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Drives the modular exponentiation block through a directed set of corner
// settings and bases, then random exponent/modulus phases with random base
// beats, random gaps on the base stream and random stalls on the result
// stream; the monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH     = modexp_pkg::WIDTH;
  localparam int DATA_W    = modexp_pkg::DATA_W;
  localparam int CFG_IDX_W = modexp_pkg::CFG_IDX_W;

  // Run shape
  localparam int RESET_CYCLES    = 9;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 8;     // margin before touching registers
  localparam int TAIL_CYCLES     = 700;   // a bit over one worst-case base
  localparam int SQUEEZE_AT      = 120;   // results taken before the long hold
  localparam int SQUEEZE_CYCLES  = 4000;  // several bases' worth of work
  // Slowest legal run is roughly 1050 beats times (worst-case base + longest
  // base gap + longest result stall); allow about four times that.
  localparam int LIMIT_CYCLES    = 8_000_000;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [WIDTH-1:0]     cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;   // [W-1:0] base
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;         // [W-1:0] power_mod
  int                   fail_count;
  int                   in_flight;

  modular_exponentiation dut (.*);

  power_mod_monitor monitor (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs on either stream.
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Gap lengths: mostly none or short, a few long enough to span a whole base.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 0;
    if (pick < 80) return $urandom_range(4, 1);
    if (pick < 95) return $urandom_range(40, 5);
    return $urandom_range(700, 100);
  endfunction

  // Bias bases toward the edges of the field and of the current modulus.
  function automatic logic [WIDTH-1:0] pick_base(logic [WIDTH-1:0] m);
    case ($urandom_range(9))
      0: return '0;
      1: return WIDTH'(1);
      2: return '1;
      3: return m - 1'b1;
      4: return m;
      5: return WIDTH'($urandom_range(m));
      default: return WIDTH'($urandom_range({WIDTH{1'b1}}));
    endcase
  endfunction

  // Offer one base beat after an idle gap; return at the accepting edge with
  // tvalid still high so a back-to-back beat needs no extra assignment.
  task automatic send_base(input logic [WIDTH-1:0] b, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(b);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop the base stream and wait until every pending result has come out.
  task automatic wait_idle(input int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write both registers on consecutive edges while the block is idle.
  task automatic set_config(input logic [WIDTH-1:0] e, input logic [WIDTH-1:0] m);
    wait_idle(SETTLE_CYCLES);
    cfg_wr_en <= 1'b1;
    cfg_index <= modexp_pkg::REG_EXPONENT;
    cfg_data  <= e;
    @(posedge clk);
    cfg_index <= modexp_pkg::REG_MODULUS;
    cfg_data  <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_data  <= '0;
  endtask

  // Result side: random stalls, an occasional calm stretch, and one long
  // hold-off that lets the block fill up and push back on the base stream.
  initial begin : result_sink
    int  results_taken;
    int  stall_left;
    int  calm_left;
    bit  squeezed;
    results_taken = 0;
    stall_left    = 0;
    calm_left     = 0;
    squeezed      = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) results_taken++;
      if (!squeezed && results_taken >= SQUEEZE_AT) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(63) == 0) begin
          stall_left = idle_len();
          if ($urandom_range(7) == 0) calm_left = 2000;
        end
      end
    end
  end

  initial begin : stimulus
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    bit               steady;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero exponent with modulus one still yields one.
    send_base('0, idle_len());
    send_base('1, idle_len());
    send_base(WIDTH'(1), idle_len());

    // Both registers at their maximum.
    set_config('1, '1);
    send_base('0, idle_len());
    send_base(WIDTH'(1), idle_len());
    send_base('1, idle_len());
    send_base(16'hFFFE, idle_len());
    send_base(16'h8000, idle_len());

    // Zero exponent with an ordinary modulus: one, whatever the base.
    set_config('0, WIDTH'(7));
    send_base('1, idle_len());
    send_base(WIDTH'(3), idle_len());

    // Modulus one with a nonzero exponent: always zero.
    set_config('1, WIDTH'(1));
    send_base(WIDTH'(2), idle_len());
    send_base('1, idle_len());

    // Exponent one: only the base reduction matters.
    set_config(WIDTH'(1), '1);
    send_base('1, idle_len());
    send_base(16'h1234, idle_len());

    // Zero modulus: products wrap at the register width.
    set_config(WIDTH'(2), '0);
    send_base('1, idle_len());
    send_base(16'h8000, idle_len());
    set_config('1, '0);
    send_base(WIDTH'(3), idle_len());
    send_base('1, idle_len());

    // Only the top exponent bit set, smallest real modulus.
    set_config(16'h8000, WIDTH'(2));
    send_base(WIDTH'(3), idle_len());

    // Random phases: fresh settings each time, some with no base gaps at all.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(5))
        0: e = '0;
        1: e = '1;
        2: e = WIDTH'(1) << $urandom_range(WIDTH - 1);
        3: e = WIDTH'($urandom_range(15));
        default: e = WIDTH'($urandom_range({WIDTH{1'b1}}));
      endcase
      case ($urandom_range(7))
        0: m = WIDTH'(1);
        1: m = '0;
        2: m = '1;
        3: m = WIDTH'($urandom_range(16, 2));
        4: m = '1 - WIDTH'($urandom_range(16));
        default: m = WIDTH'($urandom_range({WIDTH{1'b1}}, 1));
      endcase
      set_config(e, m);
      steady = ($urandom_range(3) == 0);
      repeat (ITEMS_PER_PHASE) send_base(pick_base(m), steady ? 0 : idle_len());
    end

    // Drain, then give any stray beat time to show up.
    wait_idle(TAIL_CYCLES);
    if (fail_count == 0 && in_flight == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
src/modexp_pkg.sv
src/modexp_modmul.sv
src/modular_exponentiation.sv
tb/power_mod_monitor.sv
tb/modular_exponentiation_test.sv
